[hw/rtl/ctpg_pkg.sv]
// Shared types and constants of the corner texture pixel generator.
package ctpg_pkg;

    // Input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Palette depth, also the largest corner size
    localparam int MAX_CORNER = 64;

    // Fixed field widths
    localparam int COLOR_W = 32;
    localparam int POS_W   = 6;
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int M_W     = 7;   // corner size less one, at most 63, spare bit for the clamp
    localparam int D_W     = 7;   // per-axis distance to the corner point

    // Root datapath: 16-bit radicand, 8-bit root, two digits per stage
    localparam int RAD_W       = 16;
    localparam int ROOT_W      = 8;
    localparam int REM_W       = 9;
    localparam int SQRT_STAGES = 4;
    localparam int SQRT_STEPS  = 2;

    localparam logic [COLOR_W-1:0] TRANSPARENT = 32'h0000_0000;

    // Control word that travels down the pipeline with each item
    typedef struct packed {
        logic               vld;
        logic               load;
        logic               wr_ok;
        logic               rnd;
        logic [M_W-1:0]     m;
        logic [POS_W-1:0]   sq_idx;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] entry_color;
    } ctl_t;

    // One digit of the restoring square root
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem,
                                      input logic [ROOT_W-1:0] root,
                                      input logic [1:0] pair);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        sq_t              res;
        rem_sh = {rem, pair};
        trial  = {1'b0, root, 2'b01};
        if (rem_sh >= trial)
        begin
            res.rem  = REM_W'(rem_sh - trial);
            res.root = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem_sh[REM_W-1:0];
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[hw/rtl/corner_texture_pixel_gen.sv]
// Top level of the corner texture pixel generator.
//
//  channel  | handshake               | word
//  ---------+-------------------------+--------------------------------------------
//  input    | start & !busy           | func, entry_index, entry_color, pos, rounded
//  result   | done (one-cycle strobe) | pixel_color, outside
//  config   | cfg_valid & cfg_ready   | cfg_corner_size
//
// One word is taken every cycle; busy is never raised and cfg_ready is always high.
// A pixel word's result is formed in two front stages (distance, sum of squares),
// four root stages, the palette RAM read and the output stage.
// Load words write the palette when they reach the RAM stage, keeping word order.
// Reset clears the pipeline valids and sets the corner size to 8; palette holds
// garbage until written. The receiver cannot stall, so nothing is ever held.
module corner_texture_pixel_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [ctpg_pkg::IDX_W-1:0]     entry_index,
    input  logic [ctpg_pkg::COLOR_W-1:0]   entry_color,
    input  logic [ctpg_pkg::POS_W-1:0]     pos_x,
    input  logic [ctpg_pkg::POS_W-1:0]     pos_y,
    input  logic                           rounded,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctpg_pkg::SIZE_W-1:0]    cfg_corner_size,
    output logic                           done,
    output logic [ctpg_pkg::COLOR_W-1:0]   pixel_color,
    output logic                           outside
);

    localparam int ADDR_W = $clog2(ctpg_pkg::MAX_CORNER);
    localparam int SZ_W   = 9;
    localparam int M_RESET = ((ctpg_pkg::MAX_CORNER < 8) ? ctpg_pkg::MAX_CORNER : 8) - 1;

    logic [ctpg_pkg::M_W-1:0]     m_next, m_reg;
    logic [SZ_W-1:0]              size_c;
    logic                         in_valid;

    ctpg_pkg::ctl_t               g_ctl;
    logic [ctpg_pkg::RAD_W-1:0]   g_d2;
    ctpg_pkg::ctl_t               s_ctl;
    logic [ctpg_pkg::ROOT_W-1:0]  s_root;
    logic [ctpg_pkg::REM_W-1:0]   s_rem;

    logic [ctpg_pkg::ROOT_W-1:0]  r_round;
    logic                         outside_c;
    logic [ctpg_pkg::ROOT_W-1:0]  diff_c;
    logic [ctpg_pkg::M_W-1:0]     rd_idx;
    logic [ADDR_W+ctpg_pkg::M_W-1:0] rd_wide;
    logic [ADDR_W+ctpg_pkg::IDX_W-1:0] wr_wide;
    logic                         ram_we, ram_re;
    logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
    logic [ctpg_pkg::COLOR_W-1:0] ram_rdata;

    logic                         f_vld_reg, f_out_reg;
    logic                         done_reg, outside_reg;
    logic [ctpg_pkg::COLOR_W-1:0] color_next, color_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    // Corner size register, kept as m = clamp(size, 1, MAX_CORNER) - 1
    always_comb
    begin
        size_c = SZ_W'(cfg_corner_size);
        if (size_c == '0)
        begin
            size_c = SZ_W'(1);
        end
        else if (size_c > SZ_W'(ctpg_pkg::MAX_CORNER))
        begin
            size_c = SZ_W'(ctpg_pkg::MAX_CORNER);
        end
        m_next = ctpg_pkg::M_W'(size_c - SZ_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= ctpg_pkg::M_W'(M_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            m_reg <= m_next;
        end
    end

    // Distance front end
    ctpg_geom u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .func        (func),
        .entry_index (entry_index),
        .entry_color (entry_color),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rounded     (rounded),
        .m           (m_reg),
        .ctl_out     (g_ctl),
        .d2_out      (g_d2)
    );

    // Pipelined root
    ctpg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (g_ctl),
        .d2_in    (g_d2),
        .ctl_out  (s_ctl),
        .root_out (s_root),
        .rem_out  (s_rem)
    );

    // Round half up, shape test and palette address
    always_comb
    begin
        r_round   = s_root + ctpg_pkg::ROOT_W'(s_rem > ctpg_pkg::REM_W'(s_root));
        outside_c = s_ctl.rnd && (r_round > ctpg_pkg::ROOT_W'(s_ctl.m));
        diff_c    = ctpg_pkg::ROOT_W'(s_ctl.m) - r_round;
        rd_idx    = s_ctl.rnd ? diff_c[ctpg_pkg::M_W-1:0] : ctpg_pkg::M_W'(s_ctl.sq_idx);
        rd_wide   = {ADDR_W'(0), rd_idx};
        wr_wide   = {ADDR_W'(0), s_ctl.entry_index};
        ram_raddr = rd_wide[ADDR_W-1:0];
        ram_waddr = wr_wide[ADDR_W-1:0];
        ram_we    = s_ctl.vld && s_ctl.load && s_ctl.wr_ok;
        ram_re    = s_ctl.vld && !s_ctl.load && !outside_c;
    end

    // Gradient palette
    ctpg_ram #(
        .WIDTH (ctpg_pkg::COLOR_W),
        .DEPTH (ctpg_pkg::MAX_CORNER)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_ctl.entry_color),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output select: transparent outside the shape
    always_comb
    begin
        color_next = f_out_reg ? ctpg_pkg::TRANSPARENT : ram_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            f_vld_reg <= s_ctl.vld && !s_ctl.load;
            done_reg  <= f_vld_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        f_out_reg   <= outside_c;
        outside_reg <= f_out_reg;
        color_reg   <= color_next;
    end

    assign done        = done_reg;
    assign pixel_color = color_reg;
    assign outside     = outside_reg;

endmodule

[hw/rtl/ctpg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ctpg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ctpg_geom.sv]
// Front stages: position clamp, per-axis distance, then squared distance.
module ctpg_geom (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           func,
    input  logic [ctpg_pkg::IDX_W-1:0]     entry_index,
    input  logic [ctpg_pkg::COLOR_W-1:0]   entry_color,
    input  logic [ctpg_pkg::POS_W-1:0]     pos_x,
    input  logic [ctpg_pkg::POS_W-1:0]     pos_y,
    input  logic                           rounded,
    input  logic [ctpg_pkg::M_W-1:0]       m,
    output ctpg_pkg::ctl_t                 ctl_out,
    output logic [ctpg_pkg::RAD_W-1:0]     d2_out
);

    localparam int CMP_W = ctpg_pkg::IDX_W + 10;

    ctpg_pkg::ctl_t                 a_ctl_next, a_ctl_reg;
    logic [ctpg_pkg::D_W-1:0]       dx_next, dx_reg;
    logic [ctpg_pkg::D_W-1:0]       dy_next, dy_reg;
    ctpg_pkg::ctl_t                 b_ctl_reg;
    logic [ctpg_pkg::RAD_W-1:0]     d2_next, d2_reg;
    logic [ctpg_pkg::POS_W-1:0]     xc, yc;
    logic                           a_vld_reg, b_vld_reg;

    // Stage A: clamp the position into the square, form distances
    always_comb
    begin
        xc = ({1'b0, pos_x} > m) ? m[ctpg_pkg::POS_W-1:0] : pos_x;
        yc = ({1'b0, pos_y} > m) ? m[ctpg_pkg::POS_W-1:0] : pos_y;
        a_ctl_next.vld         = in_valid;
        a_ctl_next.load        = (func == ctpg_pkg::FUNC_LOAD);
        a_ctl_next.wr_ok       = (CMP_W'(entry_index) < CMP_W'(ctpg_pkg::MAX_CORNER));
        a_ctl_next.rnd         = rounded;
        a_ctl_next.m           = m;
        a_ctl_next.sq_idx      = (xc < yc) ? xc : yc;
        a_ctl_next.entry_index = entry_index;
        a_ctl_next.entry_color = entry_color;
        dx_next = m - {1'b0, xc};
        dy_next = m - {1'b0, yc};
    end

    // Stage B: sum of squares
    always_comb
    begin
        d2_next = ctpg_pkg::RAD_W'(dx_reg * dx_reg) + ctpg_pkg::RAD_W'(dy_reg * dy_reg);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_ctl_next.vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_ctl_reg <= a_ctl_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        b_ctl_reg <= a_ctl_reg;
        d2_reg    <= d2_next;
    end

    // Control word out with its live valid bit
    always_comb
    begin
        ctl_out     = b_ctl_reg;
        ctl_out.vld = b_vld_reg;
    end

    assign d2_out = d2_reg;

endmodule

[hw/rtl/ctpg_sqrt.sv]
// Pipelined restoring integer square root, two root bits per stage.
module ctpg_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctpg_pkg::ctl_t                 ctl_in,
    input  logic [ctpg_pkg::RAD_W-1:0]     d2_in,
    output ctpg_pkg::ctl_t                 ctl_out,
    output logic [ctpg_pkg::ROOT_W-1:0]    root_out,
    output logic [ctpg_pkg::REM_W-1:0]     rem_out
);

    localparam int NS = ctpg_pkg::SQRT_STAGES;

    ctpg_pkg::ctl_t                 ctl_reg  [0:NS-1];
    logic [ctpg_pkg::RAD_W-1:0]     rad_reg  [0:NS-1];
    logic [ctpg_pkg::ROOT_W-1:0]    root_reg [0:NS-1];
    logic [ctpg_pkg::REM_W-1:0]     rem_reg  [0:NS-1];
    logic [NS-1:0]                  vld_reg;

    ctpg_pkg::ctl_t                 ctl_src  [0:NS-1];
    logic [ctpg_pkg::RAD_W-1:0]     rad_src  [0:NS-1];
    logic [ctpg_pkg::ROOT_W-1:0]    root_src [0:NS-1];
    logic [ctpg_pkg::REM_W-1:0]     rem_src  [0:NS-1];
    logic [NS-1:0]                  vld_src;

    logic [ctpg_pkg::RAD_W-1:0]     rad_next  [0:NS-1];
    logic [ctpg_pkg::ROOT_W-1:0]    root_next [0:NS-1];
    logic [ctpg_pkg::REM_W-1:0]     rem_next  [0:NS-1];

    // Stage inputs: first stage from the front end, the rest chained
    always_comb
    begin
        ctl_src[0]  = ctl_in;
        vld_src[0]  = ctl_in.vld;
        rad_src[0]  = d2_in;
        root_src[0] = '0;
        rem_src[0]  = '0;
        for (int s = 1; s < NS; s++)
        begin
            ctl_src[s]  = ctl_reg[s-1];
            vld_src[s]  = vld_reg[s-1];
            rad_src[s]  = rad_reg[s-1];
            root_src[s] = root_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
        end
    end

    // Two digits per stage, top radicand bits first
    always_comb
    begin
        ctpg_pkg::sq_t acc;
        for (int s = 0; s < NS; s++)
        begin
            acc.rem  = rem_src[s];
            acc.root = root_src[s];
            rad_next[s] = rad_src[s];
            for (int k = 0; k < ctpg_pkg::SQRT_STEPS; k++)
            begin
                acc = ctpg_pkg::sqrt_step(acc.rem, acc.root,
                                          rad_next[s][ctpg_pkg::RAD_W-1 -: 2]);
                rad_next[s] = {rad_next[s][ctpg_pkg::RAD_W-3:0], 2'b00};
            end
            root_next[s] = acc.root;
            rem_next[s]  = acc.rem;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_src;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            ctl_reg[s]  <= ctl_src[s];
            rad_reg[s]  <= rad_next[s];
            root_reg[s] <= root_next[s];
            rem_reg[s]  <= rem_next[s];
        end
    end

    // Last stage out with its live valid bit
    always_comb
    begin
        ctl_out     = ctl_reg[NS-1];
        ctl_out.vld = vld_reg[NS-1];
    end

    assign root_out = root_reg[NS-1];
    assign rem_out  = rem_reg[NS-1];

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the corner texture pixel generator.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_CORNER   = ctpg_pkg::MAX_CORNER;
    localparam int DRAIN_CYCLES = 12;     // pipeline depth plus margin
    localparam int N_PHASES     = 10;
    localparam int PHASE_WORDS  = 118;

    // One expected pixel
    typedef struct packed {
        logic [ctpg_pkg::COLOR_W-1:0] color;
        logic                         outside;
    } pixel_t;

    // Palette/corner-size shadow and the queue of expected pixels
    class corner_scoreboard;
        logic [ctpg_pkg::COLOR_W-1:0] palette [MAX_CORNER];
        logic [ctpg_pkg::SIZE_W-1:0]  corner_size;
        pixel_t                       expected_pixels[$];
        int                           errors;
        int                           loads;
        int                           pixels;
        int                           outside_cnt;

        function new();
            corner_size = 7'd8;
            errors      = 0;
            loads       = 0;
            pixels      = 0;
            outside_cnt = 0;
        endfunction

        // Palette index a pixel reads; is_out when the rounded distance exceeds m
        static function void locate(input logic [ctpg_pkg::SIZE_W-1:0] size_reg,
                                    input logic [ctpg_pkg::POS_W-1:0] x,
                                    input logic [ctpg_pkg::POS_W-1:0] y,
                                    input logic rnd,
                                    output int unsigned idx,
                                    output bit is_out);
            int unsigned size;
            int unsigned m;
            int unsigned px;
            int unsigned py;
            int unsigned dx;
            int unsigned dy;
            int unsigned d2;
            int unsigned r;
            size = size_reg;
            if (size < 1)
                size = 1;
            if (size > MAX_CORNER)
                size = MAX_CORNER;
            m  = size - 1;
            px = (x > m) ? m : x;
            py = (y > m) ? m : y;
            is_out = 1'b0;
            idx    = 0;
            if (rnd == 1'b0)
            begin
                idx = (px < py) ? px : py;
            end
            else
            begin
                dx = m - px;
                dy = m - py;
                d2 = dx * dx + dy * dy;
                // integer root, then round half up
                r = 0;
                while ((r + 1) * (r + 1) <= d2)
                    r++;
                if (d2 > r * r + r)
                    r++;
                if (r > m)
                    is_out = 1'b1;
                else
                    idx = m - r;
            end
        endfunction

        function void note_word(input logic f,
                                input logic [ctpg_pkg::IDX_W-1:0] eidx,
                                input logic [ctpg_pkg::COLOR_W-1:0] ecol,
                                input logic [ctpg_pkg::POS_W-1:0] x,
                                input logic [ctpg_pkg::POS_W-1:0] y,
                                input logic rnd);
            int unsigned idx;
            bit          is_out;
            pixel_t      exp_px;
            if (f == ctpg_pkg::FUNC_LOAD)
            begin
                palette[eidx] = ecol;
                loads++;
            end
            else
            begin
                locate(corner_size, x, y, rnd, idx, is_out);
                exp_px.outside = is_out;
                exp_px.color   = is_out ? ctpg_pkg::TRANSPARENT : palette[idx];
                expected_pixels.push_back(exp_px);
                pixels++;
                if (is_out)
                    outside_cnt++;
            end
        endfunction

        function void check_pixel(input logic [ctpg_pkg::COLOR_W-1:0] color,
                                  input logic out_flag);
            pixel_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("pixel %h outside=%b with none pending", color, out_flag));
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (color !== exp_px.color)
                report($sformatf("pixel_color %h, want %h", color, exp_px.color));
            if (out_flag !== exp_px.outside)
                report($sformatf("outside %b, want %b", out_flag, exp_px.outside));
        endfunction

        function void report(input string msg);
            if (errors < 50)
                $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           func;
    logic [ctpg_pkg::IDX_W-1:0]     entry_index;
    logic [ctpg_pkg::COLOR_W-1:0]   entry_color;
    logic [ctpg_pkg::POS_W-1:0]     pos_x;
    logic [ctpg_pkg::POS_W-1:0]     pos_y;
    logic                           rounded;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ctpg_pkg::SIZE_W-1:0]    cfg_corner_size;
    logic                           done;
    logic [ctpg_pkg::COLOR_W-1:0]   pixel_color;
    logic                           outside;

    corner_scoreboard               sb;
    logic [ctpg_pkg::SIZE_W-1:0]    cur_size;
    bit                             loaded [MAX_CORNER];

    corner_texture_pixel_gen i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .entry_index     (entry_index),
        .entry_color     (entry_color),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .rounded         (rounded),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_corner_size (cfg_corner_size),
        .done            (done),
        .pixel_color     (pixel_color),
        .outside         (outside)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Timed out waiting for pixel results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Monitor: results first, then the word and config accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_pixel(pixel_color, outside);
            if (start && !busy)
                sb.note_word(func, entry_index, entry_color, pos_x, pos_y, rounded);
            if (cfg_valid && cfg_ready)
                sb.corner_size = cfg_corner_size;
        end
    end

    // Send one word; a pixel that would read an unloaded entry loads it instead
    task automatic send_word(input logic f,
                             input logic [ctpg_pkg::IDX_W-1:0] eidx,
                             input logic [ctpg_pkg::COLOR_W-1:0] ecol,
                             input logic [ctpg_pkg::POS_W-1:0] x,
                             input logic [ctpg_pkg::POS_W-1:0] y,
                             input logic rnd);
        int unsigned idx;
        bit          is_out;
        if (f == ctpg_pkg::FUNC_PIXEL)
        begin
            sb.locate(cur_size, x, y, rnd, idx, is_out);
            if (!is_out && !loaded[idx])
            begin
                f    = ctpg_pkg::FUNC_LOAD;
                eidx = ctpg_pkg::IDX_W'(idx);
            end
        end
        if (f == ctpg_pkg::FUNC_LOAD)
            loaded[eidx] = 1'b1;
        start       <= 1'b1;
        func        <= f;
        entry_index <= eidx;
        entry_color <= ecol;
        pos_x       <= x;
        pos_y       <= y;
        rounded     <= rnd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every pending pixel is back and loads have reached the RAM
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [ctpg_pkg::SIZE_W-1:0] v);
        cfg_valid       <= 1'b1;
        cfg_corner_size <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_size   = v;
    endtask

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stimulus
    initial
    begin
        logic [ctpg_pkg::SIZE_W-1:0]  sizes [N_PHASES];
        int                           phase;
        int                           k;
        int                           burst;
        int unsigned                  m_now;
        logic                         f;
        logic [ctpg_pkg::IDX_W-1:0]   eidx;
        logic [ctpg_pkg::POS_W-1:0]   x;
        logic [ctpg_pkg::POS_W-1:0]   y;

        sb       = new();
        cur_size = 7'd8;
        burst    = 0;
        sizes    = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd40, 7'd0, 7'd0, 7'd0};
        for (k = 7; k < N_PHASES; k++)
            sizes[k] = ctpg_pkg::SIZE_W'($urandom_range(0, 127));

        rst_n           <= 1'b0;
        start           <= 1'b0;
        func            <= ctpg_pkg::FUNC_LOAD;
        entry_index     <= '0;
        entry_color     <= '0;
        pos_x           <= '0;
        pos_y           <= '0;
        rounded         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_corner_size <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset corner size of 8 (m = 7)
        send_word(ctpg_pkg::FUNC_LOAD, 6'd0, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1);
        for (k = 1; k < 8; k++)
            send_word(ctpg_pkg::FUNC_LOAD, ctpg_pkg::IDX_W'(k),
                      (k == 5) ? 32'h0 : {4{8'(k * 37)}}, 6'd0, 6'd0, 1'b0);
        send_word(ctpg_pkg::FUNC_LOAD, 6'd63, 32'h8000_0001, 6'd0, 6'd0, 1'b0);
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd63, 32'h0, 6'd0, 6'd0, 1'b0);   // square, entry 0
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd63, 6'd63, 1'b0);  // clamps to m
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd63, 6'd0, 1'b0);   // min picks y
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd7, 6'd7, 1'b1);    // corner point
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd0, 6'd0, 1'b1);    // far corner
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd1, 6'd0, 1'b1);    // just outside
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd0, 6'd7, 1'b1);    // edge, entry 0
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd6, 6'd6, 1'b1);    // 1.41 rounds down
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd4, 6'd5, 1'b1);    // 3.61 rounds up
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd3, 6'd5, 1'b1);    // 4.47 rounds down
        send_word(ctpg_pkg::FUNC_PIXEL, 6'd0, 32'h0, 6'd2, 6'd3, 1'b1);    // 6.40 rounds down

        // Random phases, one corner size each
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            drain();
            write_size(sizes[phase]);
            if (cur_size == 0)
                m_now = 0;
            else if (cur_size > MAX_CORNER)
                m_now = MAX_CORNER - 1;
            else
                m_now = cur_size - 1;
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                f    = ($urandom_range(0, 9) < 3) ? ctpg_pkg::FUNC_LOAD : ctpg_pkg::FUNC_PIXEL;
                eidx = ($urandom_range(0, 3) == 0)
                       ? ctpg_pkg::IDX_W'($urandom_range(0, 63))
                       : ctpg_pkg::IDX_W'($urandom_range(0, m_now));
                x    = ($urandom_range(0, 3) == 0)
                       ? ctpg_pkg::POS_W'($urandom_range(0, 63))
                       : ctpg_pkg::POS_W'($urandom_range(0, m_now));
                y    = ($urandom_range(0, 3) == 0)
                       ? ctpg_pkg::POS_W'($urandom_range(0, 63))
                       : ctpg_pkg::POS_W'($urandom_range(0, m_now));
                send_word(f, eidx, $urandom, x, y, 1'($urandom_range(0, 1)));
                if (k == PHASE_WORDS / 2 && phase == 3)
                    drain();
                else if (burst > 0)
                    burst--;
                else if ($urandom_range(0, 49) == 0)
                    burst = $urandom_range(20, 60);
                else
                    pause(pick_gap());
            end
        end

        drain();
        $display("Ran %0d palette loads and %0d pixels, %0d of them outside the rounded edge,",
                 sb.loads, sb.pixels, sb.outside_cnt);
        $display("over %0d corner sizes including 0, 1, 64, 65 and 127.", N_PHASES + 1);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
